// File: sv/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a must imply b on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// Property a must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, a, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) else $error(msg);

`endif

// File: sv/srq_pkg.sv
// ---------------------------------------------------------------------------
// srq_pkg: shared types and codes of the sorted ready queue
// Operation and status codes, controller states and the control interface
// between controller and datapath.
// ---------------------------------------------------------------------------
package srq_pkg;

  localparam int ID_W  = 6;
  localparam int KEY_W = 16;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_FINDMIN = 3'd4,
    OP_SORT   = 3'd5,
    OP_NOP6   = 3'd6,
    OP_NOP7   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,   // one slot a cycle: insert position, remove compaction, minimum
    S_SHIFT,  // move slots one place toward tail / head
    S_SORT,   // one bubble pass step per cycle
    S_DONE
  } state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;       // capture the operation
    logic scan_step;  // process slot at index, advance
    logic shift_up;   // slot[idx] <= slot[idx-1], idx--
    logic shift_down; // slot[idx] <= slot[idx+1], idx++
    logic place;      // write new entry at wr, count++
    logic sort_step;  // compare-swap idx/idx+1
    logic sort_restart;
    logic finish;     // latch result
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic scan_end;   // idx reached count
    logic found_pos;  // insert position found at idx
    logic shift_end;  // shift finished
    logic sort_end;   // pass end
    logic swapped;    // any swap this pass
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// File: sv/sorted_ready_queue_unit.sv
// ---------------------------------------------------------------------------
// sorted_ready_queue_unit: sorted ready queue of process ids with keys
// Top level: configuration register, controller and datapath.
// ---------------------------------------------------------------------------
// One operation at a time: start is taken while busy is low, and the result
// appears in the cycle after the operation ends, marked by result_valid for a
// single cycle; the receiver cannot stall it. Append writes the tail slot
// directly; pop, insert, remove and find minimum step through the slots; sort
// runs bubble passes, one compare-swap per cycle within a pass on the slot
// register file, and restarts the pass while any swap was made. No clearing
// pass.
`include "assert_macros.svh"

module sorted_ready_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [5:0]  process_id,
  input  logic [15:0] key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        result_valid,
  output logic [5:0]  result_id,
  output logic [15:0] result_key,
  output logic [1:0]  status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);
  import srq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       new_before_equal;
  logic       done;
  logic [2:0] cur_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_before_equal <= 1'b1;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) new_before_equal <= cfg_data;
      result_valid <= done;
    end
  end

  srq_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .done, .cur_op, .stat, .cmd
  );

  srq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_dp (
    .clk, .rst, .cmd, .stat, .operation, .process_id, .key, .new_before_equal,
    .result_id, .result_key, .status, .occupancy, .cur_op
  );

  `ASSERT_ALWAYS(a_occ_range, clk, rst, occupancy <= CNT_W'(QUEUE_DEPTH), "occupancy overflow")
  `ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy, "start not taken")
  `ASSERT_NEXT(a_done_valid, clk, rst, done, result_valid && !busy, "result not shown")
endmodule

// File: sv/srq_datapath.sv
// ---------------------------------------------------------------------------
// srq_datapath: slot storage, index counters and comparators
// Holds the queue slots and performs one slot step per cycle under control
// of the controller.
// ---------------------------------------------------------------------------
module srq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srq_pkg::dp_cmd_t     cmd,
  output srq_pkg::dp_stat_t    stat,
  input  logic [2:0]           operation,
  input  logic [5:0]           process_id,
  input  logic [15:0]          key,
  input  logic                 new_before_equal,
  output logic [5:0]           result_id,
  output logic [15:0]          result_key,
  output logic [1:0]           status,
  output logic [CNT_W-1:0]     occupancy,
  output logic [2:0]           cur_op
);
  import srq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [ID_W-1:0]  slot_ids  [QUEUE_DEPTH];
  logic [KEY_W-1:0] slot_keys [QUEUE_DEPTH];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;     // read index
  logic [CNT_W-1:0] wr;      // compaction write index; also append and insert position
  logic [2:0]       op;
  logic [ID_W-1:0]  pid;
  logic [KEY_W-1:0] nkey;
  logic             hit;
  logic             swapped;
  logic             dropped; // queue was full when the operation was taken
  logic [ID_W-1:0]  min_id;
  logic [KEY_W-1:0] min_key;
  logic             have_min;

  logic [IDX_W-1:0] ia, ib;
  logic [ID_W-1:0]  id_a, id_b;
  logic [KEY_W-1:0] key_a, key_b;

  assign ia    = idx[IDX_W-1:0];
  assign ib    = IDX_W'(idx + CNT_W'(1));
  assign id_a  = slot_ids[ia];
  assign key_a = slot_keys[ia];
  assign id_b  = slot_ids[ib];
  assign key_b = slot_keys[ib];

  always_comb begin
    stat.scan_end  = (idx >= count);
    stat.found_pos = (idx < count) &&
                     (new_before_equal ? (nkey <= key_a) : (nkey < key_a));
    stat.shift_end = (op == OP_POP) ? (idx + CNT_W'(1) >= count) : (idx == wr);
    stat.sort_end  = (idx + CNT_W'(2) > count);
    stat.swapped   = swapped;
    stat.full      = (count == CNT_W'(QUEUE_DEPTH));
    stat.empty     = (count == '0);
  end

  assign occupancy = count;
  assign cur_op    = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      status <= ST_OK;
      result_id  <= '0;
      result_key <= '0;
    end else begin
      if (cmd.load) begin
        op   <= operation;
        pid  <= process_id;
        nkey <= key;
        idx  <= '0;
        wr   <= (operation == OP_APPEND) ? count : '0;
        hit  <= 1'b0;
        swapped  <= 1'b0;
        dropped  <= (count == CNT_W'(QUEUE_DEPTH));
        have_min <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (op == OP_REMOVE) begin
          if (id_a == pid) hit <= 1'b1;
          else begin
            slot_ids[wr[IDX_W-1:0]]  <= id_a;
            slot_keys[wr[IDX_W-1:0]] <= key_a;
            wr <= wr + CNT_W'(1);
          end
        end else if (op == OP_FINDMIN) begin
          if (!have_min || key_a < min_key) begin
            min_key <= key_a;
            min_id  <= id_a;
          end
          have_min <= 1'b1;
        end
        idx <= idx + CNT_W'(1);
      end
      if (cmd.shift_up) begin
        // first call: idx = count, wr holds the insert position; move from tail down
        slot_ids[ia]  <= slot_ids[IDX_W'(idx - CNT_W'(1))];
        slot_keys[ia] <= slot_keys[IDX_W'(idx - CNT_W'(1))];
        idx <= idx - CNT_W'(1);
      end
      if (cmd.shift_down) begin
        slot_ids[ia]  <= id_b;
        slot_keys[ia] <= key_b;
        idx <= idx + CNT_W'(1);
      end
      if (cmd.place) begin
        slot_ids[wr[IDX_W-1:0]]  <= pid;
        slot_keys[wr[IDX_W-1:0]] <= nkey;
        count <= count + CNT_W'(1);
      end
      if (cmd.sort_step) begin
        if (key_a > key_b) begin
          slot_ids[ia]  <= id_b;
          slot_keys[ia] <= key_b;
          slot_ids[ib]  <= id_a;
          slot_keys[ib] <= key_a;
          swapped <= 1'b1;
        end
        idx <= idx + CNT_W'(1);
      end
      if (cmd.sort_restart) begin
        idx <= '0;
        swapped <= 1'b0;
      end
      // controller reuses scan to find insert position: mark it in wr
      if (op == OP_INSERT && cmd.scan_step == 1'b0 && cmd.shift_up == 1'b0 &&
          cmd.place == 1'b0 && cmd.load == 1'b0 && cmd.finish == 1'b0 &&
          cmd.sort_step == 1'b0) begin
        wr  <= idx;
        idx <= count;
      end
      if (cmd.finish) begin
        result_id  <= '0;
        result_key <= '0;
        status     <= ST_OK;
        unique case (op)
          OP_APPEND, OP_INSERT: if (dropped) status <= ST_FULL;
          OP_POP: begin
            if (count == '0) status <= ST_EMPTY;
            else begin
              result_id  <= min_id;
              result_key <= min_key;
              count <= count - CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            count <= wr;
            if (!hit) status <= ST_NOTFOUND;
          end
          OP_FINDMIN: begin
            if (count == '0) status <= ST_EMPTY;
            else begin
              result_id  <= min_id;
              result_key <= min_key;
            end
          end
          default: ;
        endcase
      end
      // pop: capture head when loading
      if (cmd.load && operation == OP_POP) begin
        min_id  <= slot_ids[0];
        min_key <= slot_keys[0];
      end
    end
  end
endmodule

// File: sv/srq_ctrl.sv
// ---------------------------------------------------------------------------
// srq_ctrl: operation sequencer
// Steps the datapath through scan, shift and sort passes for one operation.
// ---------------------------------------------------------------------------
module srq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         cur_op,
  input  srq_pkg::dp_stat_t  stat,
  output srq_pkg::dp_cmd_t   cmd
);
  import srq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd  = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (cur_op)
          OP_APPEND: begin
            if (!stat.full) cmd.place = 1'b1;
            state_next = S_DONE;
          end
          OP_INSERT: begin
            if (stat.full) state_next = S_DONE;
            else if (stat.found_pos || stat.scan_end) begin
              // idle cycle: datapath latches position, idx <= count
              state_next = S_SHIFT;
            end else cmd.scan_step = 1'b1;
          end
          OP_POP: begin
            if (stat.empty) state_next = S_DONE;
            else state_next = S_SHIFT;
          end
          OP_REMOVE, OP_FINDMIN: begin
            if (stat.scan_end) state_next = S_DONE;
            else cmd.scan_step = 1'b1;
          end
          OP_SORT: state_next = S_SORT;
          default: state_next = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (cur_op == OP_INSERT) begin
          if (stat.shift_end) begin
            cmd.place  = 1'b1;
            state_next = S_DONE;
          end else cmd.shift_up = 1'b1;
        end else begin
          if (stat.shift_end) state_next = S_DONE;
          else cmd.shift_down = 1'b1;
        end
      end
      S_SORT: begin
        if (stat.sort_end) begin
          if (stat.swapped) cmd.sort_restart = 1'b1;
          else state_next = S_DONE;
        end else cmd.sort_step = 1'b1;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
